// ===== rtl/rpi_pkg.sv =====
// shared types and constants for the ray / plane intersection pipeline
// no dependencies; used by rpi_div_stage and ray_plane_intersect
package rpi_pkg;

    // coordinate format
    localparam int CW      = 32;
    localparam int FB      = 16;
    localparam int THR_W   = 16;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(7);

    // internal widths
    localparam int DIFF_W  = CW + 1;          // point - origin
    localparam int PD_W    = 2 * CW;          // dir * normal
    localparam int PN_W    = DIFF_W + CW;     // diff * normal
    localparam int DEN_S   = PD_W + 2;        // signed sum of three
    localparam int NUM_S   = PN_W + 2;
    localparam int DEN_W   = DEN_S - 1;       // magnitude
    localparam int NMAG_W  = NUM_S - 1;
    localparam int REM_W   = NMAG_W + FB;     // dividend |num| << FB
    localparam int QW      = CW - 1;          // quotient bits below clamp
    localparam int CMP_W   = DEN_W + CW;      // room for den << QW
    localparam int SUM_W   = 2 * CW - FB + 1; // origin + shifted product

    localparam logic [QW-1:0] T_MAX = '1;

    // input beat
    typedef struct packed {
        logic signed [CW-1:0] ray_origin_x;
        logic signed [CW-1:0] ray_origin_y;
        logic signed [CW-1:0] ray_origin_z;
        logic signed [CW-1:0] ray_dir_x;
        logic signed [CW-1:0] ray_dir_y;
        logic signed [CW-1:0] ray_dir_z;
        logic signed [CW-1:0] plane_point_x;
        logic signed [CW-1:0] plane_point_y;
        logic signed [CW-1:0] plane_point_z;
        logic signed [CW-1:0] plane_normal_x;
        logic signed [CW-1:0] plane_normal_y;
        logic signed [CW-1:0] plane_normal_z;
    } t_ray_in;

    // result beat
    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] hit_x;
        logic signed [CW-1:0] hit_y;
        logic signed [CW-1:0] hit_z;
        logic                 saturated;
    } t_hit_out;

    // one item inside the divider pipeline
    typedef struct packed {
        logic               vld;
        logic               hit;
        logic               ovf;
        logic [DEN_W-1:0]   den;
        logic [REM_W-1:0]   rem;
        logic [QW-1:0]      quo;
        logic [3*CW-1:0]    org;
        logic [3*CW-1:0]    dir;
    } t_div_beat;

endpackage

// ===== rtl/rpi_div_stage.sv =====
// one restoring-division step of the t = num / denom pipeline, registered
// depends on rpi_pkg
module rpi_div_stage #(
    parameter int BIT = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  rpi_pkg::t_div_beat i_beat,
    output rpi_pkg::t_div_beat o_beat
);

    logic [rpi_pkg::CMP_W-1:0] den_sh;
    logic [rpi_pkg::CMP_W-1:0] rem_ext;
    logic [rpi_pkg::CMP_W-1:0] rem_sub;
    logic                      take;
    rpi_pkg::t_div_beat        n_beat;
    rpi_pkg::t_div_beat        r_beat;

    // compare remainder with shifted divisor, subtract when it fits
    always_comb begin
        den_sh  = rpi_pkg::CMP_W'(i_beat.den) << BIT;
        rem_ext = rpi_pkg::CMP_W'(i_beat.rem);
        rem_sub = rem_ext - den_sh;
        take    = (rem_ext >= den_sh);
        n_beat  = i_beat;
        if (take) begin
            n_beat.rem      = rem_sub[rpi_pkg::REM_W-1:0];
            n_beat.quo[BIT] = 1'b1;
        end
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= '0;
        end else if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule

// ===== rtl/ray_plane_intersect.sv =====
// ray / plane intersection, top level: dot products, divider chain, hit point
// depends on rpi_pkg and rpi_div_stage
//
// usage
//   input channel i_in_valid / o_in_ready carries one ray and one plane per beat
//   output channel o_out_valid / i_out_ready carries hit flag, point, saturation
//   config channel i_cfg_valid / o_cfg_ready writes the 16-bit parallel threshold;
//   it is always ready and should be written only while the block is empty
// timing
//   latency is 38 cycles from input beat to output beat: 5 setup stages
//   (difference, products, sums, magnitudes, overflow check), 31 divider stages
//   with one quotient bit each, one multiply stage and the output register
//   throughput is one beat per cycle; the 31-step divider chain is fully pipelined
// reset
//   synchronous active-low reset empties the pipeline and sets the threshold to 7
// stall
//   when the output beat waits the whole pipeline holds and o_in_ready drops;
//   a new beat is still taken in the cycle the waiting result is accepted
module ray_plane_intersect (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  rpi_pkg::t_ray_in      i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output rpi_pkg::t_hit_out     o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [rpi_pkg::THR_W-1:0] i_cfg_data
);

    localparam int CW = rpi_pkg::CW;

    logic en;
    logic [rpi_pkg::THR_W-1:0] r_thr;

    logic signed [CW-1:0] in_org [3];
    logic signed [CW-1:0] in_dir [3];
    logic signed [CW-1:0] in_pt  [3];
    logic signed [CW-1:0] in_nrm [3];

    // stage 1
    logic                              r1_vld;
    logic signed [CW-1:0]              r1_org  [3];
    logic signed [CW-1:0]              r1_dir  [3];
    logic signed [CW-1:0]              r1_nrm  [3];
    logic signed [rpi_pkg::DIFF_W-1:0] r1_diff [3];
    // stage 2
    logic                              r2_vld;
    logic signed [CW-1:0]              r2_org [3];
    logic signed [CW-1:0]              r2_dir [3];
    logic signed [rpi_pkg::PD_W-1:0]   r2_pd  [3];
    logic signed [rpi_pkg::PN_W-1:0]   r2_pn  [3];
    // stage 3
    logic                              r3_vld;
    logic signed [CW-1:0]              r3_org [3];
    logic signed [CW-1:0]              r3_dir [3];
    logic signed [rpi_pkg::DEN_S-1:0]  r3_den;
    logic signed [rpi_pkg::NUM_S-1:0]  r3_num;
    // stage 4
    logic                              den_neg;
    logic                              num_neg;
    logic [rpi_pkg::DEN_S-1:0]         den_abs;
    logic [rpi_pkg::NUM_S-1:0]         num_abs;
    logic [rpi_pkg::DEN_W-1:0]         thr_ext;
    logic                              miss;
    logic                              r4_vld;
    logic                              r4_hit;
    logic [rpi_pkg::DEN_W-1:0]         r4_den;
    logic [rpi_pkg::NMAG_W-1:0]        r4_nmag;
    logic [3*CW-1:0]                   r4_org;
    logic [3*CW-1:0]                   r4_dir;
    // stage 5 and divider chain
    rpi_pkg::t_div_beat                n5_beat;
    rpi_pkg::t_div_beat                div_beat [rpi_pkg::QW+1];
    rpi_pkg::t_div_beat                div_last;
    logic [rpi_pkg::QW-1:0]            t_val;
    // stage 6
    logic                              r6_vld;
    logic                              r6_hit;
    logic                              r6_ovf;
    logic signed [CW-1:0]              r6_org [3];
    logic signed [rpi_pkg::PD_W-1:0]   r6_p   [3];
    // output
    logic signed [CW-1:0]              hit_c  [3];
    logic [2:0]                        clamp_c;
    logic                              r_out_vld;
    rpi_pkg::t_hit_out                 r_out;
    rpi_pkg::t_hit_out                 n_out;

    // saturate origin + product back to coordinate range
    function automatic logic [CW:0] clamp_sum(input logic signed [rpi_pkg::SUM_W-1:0] s);
        logic all_same;
        logic [CW:0] res;
        all_same = (s[rpi_pkg::SUM_W-1:CW-1] == '0) || (s[rpi_pkg::SUM_W-1:CW-1] == '1);
        if (all_same) begin
            res = {1'b0, s[CW-1:0]};
        end else if (s[rpi_pkg::SUM_W-1]) begin
            res = {1'b1, 1'b1, {(CW-1){1'b0}}};
        end else begin
            res = {1'b1, 1'b0, {(CW-1){1'b1}}};
        end
        return res;
    endfunction

    // whole pipeline advances unless the output beat is stuck
    assign en          = !r_out_vld || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= rpi_pkg::THR_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    // unpack input beat
    always_comb begin
        in_org[0] = i_in.ray_origin_x;   in_org[1] = i_in.ray_origin_y;
        in_org[2] = i_in.ray_origin_z;
        in_dir[0] = i_in.ray_dir_x;      in_dir[1] = i_in.ray_dir_y;
        in_dir[2] = i_in.ray_dir_z;
        in_pt[0]  = i_in.plane_point_x;  in_pt[1]  = i_in.plane_point_y;
        in_pt[2]  = i_in.plane_point_z;
        in_nrm[0] = i_in.plane_normal_x; in_nrm[1] = i_in.plane_normal_y;
        in_nrm[2] = i_in.plane_normal_z;
    end

    // valid bits of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_in_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    // stages 1-3: difference, products, dot-product sums
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r1_org[k]  <= in_org[k];
                r1_dir[k]  <= in_dir[k];
                r1_nrm[k]  <= in_nrm[k];
                r1_diff[k] <= rpi_pkg::DIFF_W'(in_pt[k]) - rpi_pkg::DIFF_W'(in_org[k]);
                r2_org[k]  <= r1_org[k];
                r2_dir[k]  <= r1_dir[k];
                r2_pd[k]   <= rpi_pkg::PD_W'(r1_dir[k]) * rpi_pkg::PD_W'(r1_nrm[k]);
                r2_pn[k]   <= rpi_pkg::PN_W'(r1_diff[k]) * rpi_pkg::PN_W'(r1_nrm[k]);
                r3_org[k]  <= r2_org[k];
                r3_dir[k]  <= r2_dir[k];
            end
            r3_den <= rpi_pkg::DEN_S'(r2_pd[0]) + rpi_pkg::DEN_S'(r2_pd[1])
                    + rpi_pkg::DEN_S'(r2_pd[2]);
            r3_num <= rpi_pkg::NUM_S'(r2_pn[0]) + rpi_pkg::NUM_S'(r2_pn[1])
                    + rpi_pkg::NUM_S'(r2_pn[2]);
        end
    end

    // stage 4: magnitudes, parallel and behind-origin tests
    always_comb begin
        den_neg = r3_den[rpi_pkg::DEN_S-1];
        num_neg = r3_num[rpi_pkg::NUM_S-1];
        den_abs = den_neg ? rpi_pkg::DEN_S'(-r3_den) : rpi_pkg::DEN_S'(r3_den);
        num_abs = num_neg ? rpi_pkg::NUM_S'(-r3_num) : rpi_pkg::NUM_S'(r3_num);
        thr_ext = rpi_pkg::DEN_W'({r_thr, {rpi_pkg::FB{1'b0}}});
        miss    = (r3_den == '0)
               || (den_abs[rpi_pkg::DEN_W-1:0] < thr_ext)
               || ((r3_num != '0) && (num_neg != den_neg));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_hit  <= !miss;
            r4_den  <= den_abs[rpi_pkg::DEN_W-1:0];
            r4_nmag <= num_abs[rpi_pkg::NMAG_W-1:0];
            r4_org  <= {r3_org[2], r3_org[1], r3_org[0]};
            r4_dir  <= {r3_dir[2], r3_dir[1], r3_dir[0]};
        end
    end

    // stage 5: dividend and quotient overflow check
    always_comb begin
        n5_beat     = '0;
        n5_beat.vld = r4_vld;
        n5_beat.hit = r4_hit;
        n5_beat.den = r4_den;
        n5_beat.rem = {r4_nmag, {rpi_pkg::FB{1'b0}}};
        n5_beat.ovf = rpi_pkg::CMP_W'(n5_beat.rem)
                   >= (rpi_pkg::CMP_W'(r4_den) << rpi_pkg::QW);
        n5_beat.org = r4_org;
        n5_beat.dir = r4_dir;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            div_beat[0] <= '0;
        end else if (en) begin
            div_beat[0] <= n5_beat;
        end
    end

    // divider chain, most significant quotient bit first
    for (genvar g = 0; g < rpi_pkg::QW; g++) begin : g_div
        rpi_div_stage #(
            .BIT (rpi_pkg::QW - 1 - g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_beat  (div_beat[g]),
            .o_beat  (div_beat[g+1])
        );
    end

    assign div_last = div_beat[rpi_pkg::QW];
    assign t_val    = div_last.ovf ? rpi_pkg::T_MAX : div_last.quo;

    // stage 6: dir * t
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= div_last.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_hit <= div_last.hit;
            r6_ovf <= div_last.ovf;
            for (int k = 0; k < 3; k++) begin
                r6_org[k] <= div_last.org[k*CW +: CW];
                r6_p[k]   <= rpi_pkg::PD_W'($signed(div_last.dir[k*CW +: CW]))
                           * rpi_pkg::PD_W'($signed({1'b0, t_val}));
            end
        end
    end

    // output stage: shift, add origin, clamp
    always_comb begin
        logic signed [rpi_pkg::PD_W-1:0]  sh;
        logic signed [rpi_pkg::SUM_W-1:0] s;
        logic [CW:0]                      c;
        for (int k = 0; k < 3; k++) begin
            sh         = r6_p[k] >>> rpi_pkg::FB;
            s          = rpi_pkg::SUM_W'(r6_org[k]) + sh[rpi_pkg::SUM_W-1:0];
            c          = clamp_sum(s);
            clamp_c[k] = c[CW];
            hit_c[k]   = c[CW-1:0];
        end
        n_out = '0;
        if (r6_hit) begin
            n_out.hit       = 1'b1;
            n_out.hit_x     = hit_c[0];
            n_out.hit_y     = hit_c[1];
            n_out.hit_z     = hit_c[2];
            n_out.saturated = r6_ovf || (clamp_c != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // a miss beat carries nothing but zeros
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.hit) |-> (o_out.hit_x == '0 && o_out.hit_y == '0
            && o_out.hit_z == '0 && !o_out.saturated))
        else $error("miss beat with nonzero payload");

    // input side only blocks while the output beat is held
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // divider overflow always shows up as saturation on a hit
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r6_vld && r6_hit && r6_ovf) |=> (o_out_valid && o_out.saturated))
        else $error("quotient clamp lost its saturation flag");

endmodule

// ===== sim/tb.sv =====
// testbench for ray_plane_intersect: random and directed ray / plane beats
// depends on rpi_pkg and the ray_plane_intersect rtl
`timescale 1ns / 100ps

module tb;

    localparam int LATENCY    = 38;
    localparam int WATCH_MAX  = 20000;
    localparam int N_RANDOM   = 1430;
    localparam int CW         = rpi_pkg::CW;
    localparam int FB         = rpi_pkg::FB;
    localparam int THR_W      = rpi_pkg::THR_W;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    rpi_pkg::t_ray_in     i_in;
    logic                 o_out_valid;
    logic                 i_out_ready;
    rpi_pkg::t_hit_out    o_out;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [THR_W-1:0]     i_cfg_data;

    ray_plane_intersect dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // shadow copy of the threshold register
    logic [THR_W-1:0] thr_shadow;

    rpi_pkg::t_ray_in  ray_queue[$];
    rpi_pkg::t_hit_out hit_queue[$];

    int  n_errors;
    int  n_hits;
    int  n_sat;
    int  n_results;
    int  idle_cycles;
    bit  hold_off;
    bit  timed_out;
    int  burst_left;
    int  gap_left;
    int  stall_phase;

    // input beat taken at the last rising edge
    bit  in_taken;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // expected hit for one ray beat, at exact wide precision
    function automatic rpi_pkg::t_hit_out hit_point(rpi_pkg::t_ray_in r,
                                                    logic [THR_W-1:0] thr);
        rpi_pkg::t_hit_out    res;
        logic signed [CW-1:0] org[3], dir[3], pt[3], nrm[3];
        logic signed [127:0]  den, num, anum, aden, prod, sum;
        logic [127:0]         tq;
        logic signed [127:0]  tval;
        bit                   sat;
        res = '0;
        org = '{r.ray_origin_x, r.ray_origin_y, r.ray_origin_z};
        dir = '{r.ray_dir_x, r.ray_dir_y, r.ray_dir_z};
        pt  = '{r.plane_point_x, r.plane_point_y, r.plane_point_z};
        nrm = '{r.plane_normal_x, r.plane_normal_y, r.plane_normal_z};
        den = 0;
        num = 0;
        sat = 0;
        for (int i = 0; i < 3; i++) begin
            den = den + 128'(dir[i]) * 128'(nrm[i]);
            num = num + (128'(pt[i]) - 128'(org[i])) * 128'(nrm[i]);
        end
        aden = den < 0 ? -den : den;
        anum = num < 0 ? -num : num;
        // parallel ray or zero denominator
        if (den == 0 || aden < (128'(thr) <<< FB))
            return res;
        // plane behind the origin
        if (num != 0 && ((num < 0) != (den < 0)))
            return res;
        tq = (128'(anum) << FB) / 128'(aden);
        if (tq > 128'(rpi_pkg::T_MAX)) begin
            tq = 128'(rpi_pkg::T_MAX);
            sat = 1;
        end
        tval = $signed(tq);
        res.hit = 1'b1;
        for (int i = 0; i < 3; i++) begin
            prod = (128'(dir[i]) * tval) >>> FB;
            sum = 128'(org[i]) + prod;
            if (sum > 128'(2147483647)) begin
                sum = 128'(2147483647);
                sat = 1;
            end else if (sum < -128'sd2147483648) begin
                sum = -128'sd2147483648;
                sat = 1;
            end
            case (i)
                0: res.hit_x = sum[CW-1:0];
                1: res.hit_y = sum[CW-1:0];
                default: res.hit_z = sum[CW-1:0];
            endcase
        end
        res.saturated = sat;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // driver: bursts of beats with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_taken) begin
                if (ray_queue.size() > 0 && !hold_off && gap_left == 0) begin
                    i_in <= ray_queue.pop_front();
                    i_in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(0, 30);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left <= gap_left - 1;
                end
            end
            // receiver stall pattern: stretches of full speed, light stall, heavy stall and alternation
            stall_phase <= stall_phase + 1;
            case ((stall_phase / 200) % 4)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 3) != 0);
                2: i_out_ready <= ($urandom_range(0, 3) == 0);
                default: i_out_ready <= stall_phase[2];
            endcase
        end
    end

    // monitor: predicts on input beats, checks output beats
    always @(posedge i_clk) begin
        rpi_pkg::t_hit_out want;
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                hit_queue.push_back(hit_point(i_in, thr_shadow));
            end
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (hit_queue.size() == 0) begin
                    report_mismatch("unexpected beat", 64'(o_out.hit), 64'd0);
                end else begin
                    want = hit_queue.pop_front();
                    if (o_out.hit != want.hit)
                        report_mismatch("hit", 64'(o_out.hit), 64'(want.hit));
                    if (o_out.hit_x != want.hit_x)
                        report_mismatch("hit_x", 64'(o_out.hit_x), 64'(want.hit_x));
                    if (o_out.hit_y != want.hit_y)
                        report_mismatch("hit_y", 64'(o_out.hit_y), 64'(want.hit_y));
                    if (o_out.hit_z != want.hit_z)
                        report_mismatch("hit_z", 64'(o_out.hit_z), 64'(want.hit_z));
                    if (o_out.saturated != want.saturated)
                        report_mismatch("saturated", 64'(o_out.saturated),
                                        64'(want.saturated));
                    if (want.hit) n_hits++;
                    if (want.saturated) n_sat++;
                end
            end
            // watchdog on cycles without any beat moving while work is pending
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (ray_queue.size() == 0 && hit_queue.size() == 0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCH_MAX && !timed_out) begin
            timed_out = 1;
            $display("watchdog expired with %0d results outstanding", hit_queue.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 8) << 16;
            3: return 32'($signed($urandom_range(0, 200000)) - 100000);
            4: return 32'($signed($urandom_range(0, 2000000000)) - 1000000000);
            default: return $urandom;
        endcase
    endfunction

    // a random ray and plane: mostly small coordinates, sometimes extreme values
    function automatic rpi_pkg::t_ray_in rand_ray();
        rpi_pkg::t_ray_in r;
        logic [CW*12-1:0] flat;
        if ($urandom_range(0, 4) == 0) begin
            for (int i = 0; i < 12; i++)
                flat[i*CW +: CW] = rand_coord();
            r = flat;
        end else begin
            for (int i = 0; i < 12; i++)
                flat[i*CW +: CW] = 32'($signed($urandom_range(0, 2000000)) - 1000000) <<<
                                   $urandom_range(0, 8);
            r = flat;
            // sometimes an axis-aligned normal or a parallel ray
            if ($urandom_range(0, 3) == 0) begin
                r.plane_normal_x = 0;
                r.plane_normal_y = 0;
                r.plane_normal_z = 32'sh0001_0000;
                if ($urandom_range(0, 1)) r.ray_dir_z = $urandom_range(0, 8);
            end
        end
        return r;
    endfunction

    function automatic rpi_pkg::t_ray_in make_ray(logic [CW-1:0] o, logic [CW-1:0] d,
                                                  logic [CW-1:0] p, logic [CW-1:0] n);
        rpi_pkg::t_ray_in r;
        r = '{o, o, o, d, d, d, p, p, p, n, n, n};
        return r;
    endfunction

    task automatic write_threshold(logic [THR_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        thr_shadow = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (ray_queue.size() > 0 || i_in_valid || hit_queue.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // stimulus and end of run
    initial begin
        logic [THR_W-1:0] thr_set[4];
        rpi_pkg::t_ray_in r;
        n_errors = 0; n_hits = 0; n_sat = 0; n_results = 0;
        idle_cycles = 0; hold_off = 0; timed_out = 0;
        burst_left = 0; gap_left = 0; stall_phase = 0; in_taken = 0;
        thr_shadow = rpi_pkg::THR_RESET;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_in = '0; i_out_ready = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_data = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, parallel, zero denominator, behind, on-plane, clamps
        ray_queue.push_back('0);
        ray_queue.push_back(make_ray(0, 32'h0001_0000, 32'h0005_0000, 32'h0001_0000));
        ray_queue.push_back(make_ray(0, 32'h0001_0000, 32'hFFFB_0000, 32'h0001_0000));
        ray_queue.push_back(make_ray(32'h0003_0000, 32'h0001_0000, 32'h0003_0000,
                                     32'h0001_0000));
        ray_queue.push_back(make_ray(0, 32'h0000_0001, 32'h0005_0000, 32'h0000_0001));
        ray_queue.push_back(make_ray(0, 32'h0000_0002, 32'h0005_0000, 32'h0001_0000));
        ray_queue.push_back(make_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                     32'h8000_0000));
        ray_queue.push_back(make_ray(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                     32'h8000_0000));
        ray_queue.push_back(make_ray(32'h8000_0000, 32'h0000_0100, 32'h7FFF_FFFF,
                                     32'h0001_0000));
        ray_queue.push_back(make_ray(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                                     32'hFFFF_FFFF));
        ray_queue.push_back(make_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF));
        r = '0;
        r.ray_dir_x = 32'sh0001_0000;
        r.plane_normal_y = 32'sh0001_0000;
        ray_queue.push_back(r);
        for (int i = 0; i < 8; i++) ray_queue.push_back(rand_ray());
        drain();

        // random phases across threshold settings, extremes included
        thr_set = '{16'hFFFF, 16'h0000, 16'h0001, rpi_pkg::THR_RESET};
        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) write_threshold(ph == 4 ? 16'($urandom) : thr_set[ph-1]);
            for (int i = 0; i < N_RANDOM / 5; i++) ray_queue.push_back(rand_ray());
            // sender pauses until every result has come
            if (ph == 2) begin
                while (ray_queue.size() >= 100) @(posedge i_clk);
                hold_off = 1;
                while (i_in_valid || hit_queue.size() > 0) @(posedge i_clk);
                hold_off = 0;
            end
            drain();
        end

        $display("%0d results checked, %0d hits, %0d saturated, thresholds 0 to 65535",
                 n_results, n_hits, n_sat);
        if (n_errors == 0 && !timed_out) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
